@@ rtl/core/rrpc_pkg.sv @@
// Shared constants, types and a helper function of the range reading plausibility check.
package rrpc_pkg;

   // Width of the sensor readings and registers.
   localparam int DATA_W = 16;

   // Number of history entries, the newest of which is the sample at hand.
   localparam int HIST_DEPTH = 6;
   // Stored entries: the earlier samples that a new one is checked against.
   localparam int OLD_N = HIST_DEPTH - 1;
   // Sample counter saturates at the history depth.
   localparam int CNT_W = $clog2(HIST_DEPTH + 1);
   // Close-entry counter holds up to OLD_N.
   localparam int CLOSE_W = $clog2(HIST_DEPTH);
   // Close entries needed for a checked accept.
   localparam int MIN_CLOSE = HIST_DEPTH / 2;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_WINDOW    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISPARITY_LIMIT = 2'd1;

   // Register reset values.
   localparam logic [DATA_W-1:0] MATCH_WINDOW_RST    = 16'd10;
   localparam logic [DATA_W-1:0] DISPARITY_LIMIT_RST = 16'd10;

   // Item action codes.
   localparam logic ACTION_SAMPLE  = 1'b0;
   localparam logic ACTION_RESTART = 1'b1;

   // Verdict codes of a result item.
   typedef enum logic [1:0] {
      VERDICT_WARMUP    = 2'd0,
      VERDICT_CHECKED   = 2'd1,
      VERDICT_FEW_CLOSE = 2'd2,
      VERDICT_DISPARITY = 2'd3
   } verdict_type;

   // Absolute difference of two unsigned readings.
   function automatic logic [DATA_W-1:0] absdiff(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
      absdiff = (a >= b) ? (a - b) : (b - a);
   endfunction

endpackage

@@ rtl/core/rrpc_if.sv @@
// Channel interfaces of the range reading plausibility check: sample, result and register write.

// Sample channel: action, range reading and barometric depth.
interface rrpc_req_if;
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic [rrpc_pkg::DATA_W-1:0]   range_cm;
   logic [rrpc_pkg::DATA_W-1:0]   baro_cm;

   modport source (output valid, output action, output range_cm, output baro_cm,
                   input ready);
   modport sink   (input valid, input action, input range_cm, input baro_cm,
                   output ready);
endinterface

// Result channel: accept flag, verdict and held altitude.
interface rrpc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          reading_valid;
   logic [1:0]                    verdict;
   logic [rrpc_pkg::DATA_W-1:0]   held_alt_cm;

   modport source (output valid, output reading_valid, output verdict, output held_alt_cm,
                   input ready);
   modport sink   (input valid, input reading_valid, input verdict, input held_alt_cm,
                   output ready);
endinterface

// Register write channel: register index and write data.
interface rrpc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [rrpc_pkg::CSR_IDX_W-1:0]   index;
   logic [rrpc_pkg::DATA_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/range_reading_plausibility_check.sv @@
// Top level of the range reading plausibility check.
//
// Each sample item carries a rangefinder altitude and a barometric depth in
// centimeters; the block checks the new range reading against the previous
// five samples and returns one result item per sample (none for a restart).
// The first five samples after reset or restart are accepted as warm-up.
// Later samples need at least three earlier readings strictly within
// match_window of the new one, and for the newest of those the range change
// and depth change must differ by at most disparity_limit. A rejected sample
// reports the truncated average of the new and previous reading as the held
// altitude. One item is accepted per cycle while the input side does not stall;
// each accepted item passes through the input register, and its result is then
// held in the result register until it is taken.
// The input side stalls only when the result register is full and not taken
// while the input register also holds an item.
// Register writes are taken at once and must be made while no item is in
// flight.
module range_reading_plausibility_check (
   input  logic             clock,
   input  logic             reset,
   rrpc_req_if.sink         req_chan,
   rrpc_rsp_if.source       rsp_chan,
   rrpc_csr_if.sink         csr_chan
);

   // Configuration registers.
   logic [rrpc_pkg::DATA_W-1:0]   match_window_ff;
   logic [rrpc_pkg::DATA_W-1:0]   disparity_limit_ff;

   // Input stage.
   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_action_ff;
   logic [rrpc_pkg::DATA_W-1:0]   s1_range_ff;
   logic [rrpc_pkg::DATA_W-1:0]   s1_baro_ff;

   // Earlier samples, entry 0 the previous one.
   logic [rrpc_pkg::DATA_W-1:0]   range_hist_ff [rrpc_pkg::OLD_N];
   logic [rrpc_pkg::DATA_W-1:0]   depth_hist_ff [rrpc_pkg::OLD_N];
   logic [rrpc_pkg::CNT_W-1:0]    cnt_ff, cnt_in;

   // Result register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_reading_valid_ff, rsp_reading_valid_in;
   rrpc_pkg::verdict_type         rsp_verdict_ff, rsp_verdict_in;
   logic [rrpc_pkg::DATA_W-1:0]   rsp_held_ff, rsp_held_in;

   // Handshake and step control.
   logic                          advance;
   logic                          accept;
   logic                          step;
   logic                          restart;

   // Check datapath.
   logic [rrpc_pkg::OLD_N-1:0]    close;
   logic [rrpc_pkg::DATA_W-1:0]   rdiff [rrpc_pkg::OLD_N];
   logic [rrpc_pkg::CLOSE_W-1:0]  close_cnt;
   logic [rrpc_pkg::DATA_W-1:0]   d_range;
   logic [rrpc_pkg::DATA_W-1:0]   first_depth;
   logic [rrpc_pkg::DATA_W-1:0]   d_depth;
   logic                          warmup;
   logic                          disparity;
   logic [rrpc_pkg::DATA_W:0]     avg_sum;

   // Register writes are always taken.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_window_ff    <= rrpc_pkg::MATCH_WINDOW_RST;
         disparity_limit_ff <= rrpc_pkg::DISPARITY_LIMIT_RST;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            rrpc_pkg::CSR_MATCH_WINDOW:    match_window_ff    <= csr_chan.data;
            rrpc_pkg::CSR_DISPARITY_LIMIT: disparity_limit_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // The pipeline moves whenever the result register is free or being emptied.
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;
   assign step           = s1_valid_ff && advance;
   assign restart        = (s1_action_ff == rrpc_pkg::ACTION_RESTART);

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_action_ff <= req_chan.action;
         s1_range_ff  <= req_chan.range_cm;
         s1_baro_ff   <= req_chan.baro_cm;
      end
   end

   // Compare the new reading with every earlier one in parallel.
   always_comb begin
      close_cnt = '0;
      for (int i = 0; i < rrpc_pkg::OLD_N; i++) begin
         rdiff[i]  = rrpc_pkg::absdiff(s1_range_ff, range_hist_ff[i]);
         close[i]  = (rdiff[i] < match_window_ff);
         close_cnt = close_cnt + rrpc_pkg::CLOSE_W'(close[i]);
      end
   end

   // Pick the newest close entry; later iterations win, so run oldest first.
   always_comb begin
      d_range     = '0;
      first_depth = s1_baro_ff;
      for (int i = rrpc_pkg::OLD_N - 1; i >= 0; i--) begin
         if (close[i]) begin
            d_range     = rdiff[i];
            first_depth = depth_hist_ff[i];
         end
      end
   end

   // Sample count saturates at the history depth; warm-up lasts until then.
   always_comb begin
      if (cnt_ff < rrpc_pkg::CNT_W'(rrpc_pkg::HIST_DEPTH)) begin
         cnt_in = cnt_ff + rrpc_pkg::CNT_W'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   assign warmup    = (cnt_in < rrpc_pkg::CNT_W'(rrpc_pkg::HIST_DEPTH));
   assign d_depth   = rrpc_pkg::absdiff(s1_baro_ff, first_depth);
   assign disparity = (rrpc_pkg::absdiff(d_range, d_depth) > disparity_limit_ff);
   assign avg_sum   = {1'b0, s1_range_ff} + {1'b0, range_hist_ff[0]};

   // Verdict and held altitude of the sample in the input stage.
   always_comb begin
      if (warmup) begin
         rsp_verdict_in       = rrpc_pkg::VERDICT_WARMUP;
         rsp_reading_valid_in = 1'b1;
      end else if (close_cnt < rrpc_pkg::CLOSE_W'(rrpc_pkg::MIN_CLOSE)) begin
         rsp_verdict_in       = rrpc_pkg::VERDICT_FEW_CLOSE;
         rsp_reading_valid_in = 1'b0;
      end else if (disparity) begin
         rsp_verdict_in       = rrpc_pkg::VERDICT_DISPARITY;
         rsp_reading_valid_in = 1'b0;
      end else begin
         rsp_verdict_in       = rrpc_pkg::VERDICT_CHECKED;
         rsp_reading_valid_in = 1'b1;
      end
      rsp_held_in = rsp_reading_valid_in ? s1_range_ff : avg_sum[rrpc_pkg::DATA_W:1];
   end

   // History and count: restart clears, a sample shifts in.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         for (int i = 0; i < rrpc_pkg::OLD_N; i++) begin
            range_hist_ff[i] <= '0;
            depth_hist_ff[i] <= '0;
         end
      end else if (step) begin
         if (restart) begin
            cnt_ff <= '0;
            for (int i = 0; i < rrpc_pkg::OLD_N; i++) begin
               range_hist_ff[i] <= '0;
               depth_hist_ff[i] <= '0;
            end
         end else begin
            cnt_ff           <= cnt_in;
            range_hist_ff[0] <= s1_range_ff;
            depth_hist_ff[0] <= s1_baro_ff;
            for (int i = 1; i < rrpc_pkg::OLD_N; i++) begin
               range_hist_ff[i] <= range_hist_ff[i-1];
               depth_hist_ff[i] <= depth_hist_ff[i-1];
            end
         end
      end
   end

   // Result register: a sample loads it, a restart leaves it empty.
   always_comb begin
      if (step) begin
         rsp_valid_in = !restart;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && !restart) begin
         rsp_reading_valid_ff <= rsp_reading_valid_in;
         rsp_verdict_ff       <= rsp_verdict_in;
         rsp_held_ff          <= rsp_held_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.reading_valid = rsp_reading_valid_ff;
   assign rsp_chan.verdict       = rsp_verdict_ff;
   assign rsp_chan.held_alt_cm   = rsp_held_ff;

`ifndef SYNTH
   // A restart item never produces a result.
   a_restart_silent: assert property (@(posedge clock) disable iff (reset)
      (step && restart) |=> !rsp_valid_ff)
      else $error("restart item produced a result");

   // The accept flag agrees with the verdict.
   a_flag_matches_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_reading_valid_ff ==
         (rsp_verdict_ff == rrpc_pkg::VERDICT_WARMUP ||
          rsp_verdict_ff == rrpc_pkg::VERDICT_CHECKED)))
      else $error("accept flag disagrees with verdict");

   // A warm-up verdict is only given before the count saturates.
   a_warmup_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_verdict_ff == rrpc_pkg::VERDICT_WARMUP) |->
         (cnt_ff < rrpc_pkg::CNT_W'(rrpc_pkg::HIST_DEPTH)))
      else $error("warm-up verdict after count saturated");

   // A result that is held back keeps the pipeline still.
   a_stall_freezes_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !step)
      else $error("sample stepped while result stalled");

   // Reset empties both stages and the count.
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid_ff && !s1_valid_ff && cnt_ff == '0))
      else $error("state not cleared by reset");
`endif

endmodule
